@@ src/rcbd_pkg.sv @@
// Package for the RC discharge button decoder.
// Holds shared widths, register indexes, button codes, word types and the threshold ladder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcbd_pkg;

    localparam int TIME_BITS   = 16;
    localparam int ELAPSED_W   = 16;
    localparam int CHARGE_W    = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int BUTTON_W    = 4;

    localparam logic [CHARGE_W-1:0]  CHARGE_POLLS_RESET  = CHARGE_W'(240);
    localparam logic [TIMEOUT_W-1:0] PRESS_TIMEOUT_RESET = TIMEOUT_W'(1000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHARGE_POLLS  = 1'b0,
        CFG_PRESS_TIMEOUT = 1'b1
    } t_cfg_reg;

    typedef enum logic [BUTTON_W-1:0] {
        BTN_NONE      = 4'd0,
        BTN_VOL_PLUS  = 4'd1,
        BTN_VOL_MINUS = 4'd2,
        BTN_PLUS      = 4'd3,
        BTN_MINUS     = 4'd4,
        BTN_PLAY      = 4'd5,
        BTN_STOP      = 4'd6,
        BTN_FWD       = 4'd7,
        BTN_REV       = 4'd8
    } t_button;

    typedef enum logic [3:0] {
        PH_DRIVE   = 4'b0001,
        PH_CHARGE  = 4'b0010,
        PH_RELEASE = 4'b0100,
        PH_WAIT    = 4'b1000
    } t_phase;

    localparam logic [TIME_BITS-1:0] TH_NONE      = TIME_BITS'(230);
    localparam logic [TIME_BITS-1:0] TH_PLUS      = TIME_BITS'(200);
    localparam logic [TIME_BITS-1:0] TH_VOL_PLUS  = TIME_BITS'(170);
    localparam logic [TIME_BITS-1:0] TH_VOL_MINUS = TIME_BITS'(140);
    localparam logic [TIME_BITS-1:0] TH_STOP      = TIME_BITS'(120);
    localparam logic [TIME_BITS-1:0] TH_MINUS     = TIME_BITS'(90);
    localparam logic [TIME_BITS-1:0] TH_FWD       = TIME_BITS'(65);
    localparam logic [TIME_BITS-1:0] TH_PLAY      = TIME_BITS'(26);
    localparam logic [TIME_BITS-1:0] TH_REV       = TIME_BITS'(15);

    typedef struct packed {
        logic                 comparator_high;
        logic [TIME_BITS-1:0] time_now;
    } t_poll;

    typedef struct packed {
        logic                 drive_high;
        logic                 measure_done;
        logic [ELAPSED_W-1:0] elapsed_ticks;
        t_button              button_code;
        logic                 pressed;
    } t_result;

    function automatic t_button decode_button(input logic [TIME_BITS-1:0] t);
        t_button code;
        if (t > TH_NONE) begin
            code = BTN_NONE;
        end else if (t > TH_PLUS) begin
            code = BTN_PLUS;
        end else if (t > TH_VOL_PLUS) begin
            code = BTN_VOL_PLUS;
        end else if (t > TH_VOL_MINUS) begin
            code = BTN_VOL_MINUS;
        end else if (t > TH_STOP) begin
            code = BTN_STOP;
        end else if (t > TH_MINUS) begin
            code = BTN_MINUS;
        end else if (t > TH_FWD) begin
            code = BTN_FWD;
        end else if (t > TH_PLAY) begin
            code = BTN_PLAY;
        end else if (t > TH_REV) begin
            code = BTN_REV;
        end else begin
            code = BTN_NONE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ src/rc_discharge_button_decoder_top.sv @@
// RC discharge button decoder: a resistor-ladder keypad read by the discharge time of its sense line.
//
// Each input word is one poll: the comparator level and the free-running tick counter.
// Every poll gives exactly one result word: the sense line drive, a capture flag with the
// elapsed ticks and the decoded button, and the pressed level flag.
// The configuration channel writes charge_polls (index 0) and press_timeout (index 1);
// it is always ready; the user must write it only while no poll is in flight, the block does not enforce it.
// After its poll is accepted, the poll sits in the input register, then the phase machine and
// threshold ladder load the result register, whose word a ready receiver then takes.
// Throughput is one poll per cycle while the receiver does not stall, as the phase state updates per poll.
// Reset clears the phase machine to the drive phase, the pressed flag, the valid flags of both
// word registers, and loads charge_polls with 240 and press_timeout with 1000.
// When the receiver stalls, the result register holds its word, the input register fills,
// and o_in_ready drops until the receiver takes the waiting result.
// Depends on rcbd_pkg, rcbd_in_stage, rcbd_core and rcbd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module rc_discharge_button_decoder_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_comparator_high,
    input  wire  [rcbd_pkg::TIME_BITS-1:0]   i_time_now,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_drive_high,
    output logic                             o_measure_done,
    output logic [rcbd_pkg::ELAPSED_W-1:0]   o_elapsed_ticks,
    output logic [rcbd_pkg::BUTTON_W-1:0]    o_button_code,
    output logic                             o_pressed,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [rcbd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [rcbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rcbd_pkg::*;

    logic    stage_valid;
    t_poll   stage_poll;
    logic    advance;
    t_result result;

    assign o_cfg_ready = 1'b1;

    rcbd_in_stage u_in_stage (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_comparator_high (i_comparator_high),
        .i_time_now        (i_time_now),
        .i_advance         (advance),
        .o_valid           (stage_valid),
        .o_poll            (stage_poll)
    );

    rcbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (stage_valid && advance),
        .i_poll      (stage_poll),
        .o_result    (result)
    );

    rcbd_out_stage u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (stage_valid),
        .i_result        (result),
        .o_advance       (advance),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_high    (o_drive_high),
        .o_measure_done  (o_measure_done),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_button_code   (o_button_code),
        .o_pressed       (o_pressed)
    );

endmodule

`default_nettype wire

@@ src/rcbd_in_stage.sv @@
// Input register of the RC discharge button decoder.
// Holds one accepted poll word until the core takes it; depends on rcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcbd_in_stage (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_comparator_high,
    input  wire  [rcbd_pkg::TIME_BITS-1:0] i_time_now,
    input  wire                          i_advance,
    output logic                         o_valid,
    output rcbd_pkg::t_poll              o_poll
);
    import rcbd_pkg::*;

    logic  r_valid;
    t_poll r_poll;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_poll     = r_poll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_poll.comparator_high <= i_comparator_high;
            r_poll.time_now        <= i_time_now;
        end
    end

endmodule

`default_nettype wire

@@ src/rcbd_core.sv @@
// Phase machine, configuration registers and result logic of the RC discharge button decoder.
// Depends on rcbd_pkg for types, widths and the threshold ladder.
`timescale 1ns / 1ps
`default_nettype none

module rcbd_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire  [rcbd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [rcbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_step,
    input  rcbd_pkg::t_poll                 i_poll,
    output rcbd_pkg::t_result               o_result
);
    import rcbd_pkg::*;

    logic [CHARGE_W-1:0]  r_charge_polls;
    logic [TIMEOUT_W-1:0] r_press_timeout;

    t_phase               r_phase,        n_phase;
    logic [CHARGE_W-1:0]  r_charge_count, n_charge_count;
    logic [TIME_BITS-1:0] r_start_stamp,  n_start_stamp;
    logic                 r_pressed,      n_pressed;
    logic                 r_pin_driven,   n_pin_driven;

    logic [TIME_BITS-1:0] diff;
    t_button              button;
    logic                 done;

    assign diff   = i_poll.time_now - r_start_stamp;
    assign button = decode_button(diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_polls  <= CHARGE_POLLS_RESET;
            r_press_timeout <= PRESS_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CHARGE_POLLS:  r_charge_polls  <= i_cfg_data[CHARGE_W-1:0];
                CFG_PRESS_TIMEOUT: r_press_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default:           r_charge_polls  <= r_charge_polls;
            endcase
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_charge_count = r_charge_count;
        n_start_stamp  = r_start_stamp;
        n_pressed      = r_pressed;
        n_pin_driven   = r_pin_driven;
        done           = 1'b0;
        case (r_phase)
            PH_DRIVE: begin
                n_pin_driven = 1'b1;
                n_phase      = PH_CHARGE;
            end
            PH_CHARGE: begin
                if (r_charge_count >= r_charge_polls) begin
                    n_phase        = PH_RELEASE;
                    n_charge_count = '0;
                end else begin
                    n_charge_count = r_charge_count + CHARGE_W'(1);
                end
            end
            PH_RELEASE: begin
                n_start_stamp = i_poll.time_now;
                n_pin_driven  = 1'b0;
                n_phase       = PH_WAIT;
            end
            PH_WAIT: begin
                if (i_poll.comparator_high) begin
                    done      = 1'b1;
                    n_pressed = 1'b1;
                    n_phase   = PH_DRIVE;
                end
                if (diff > TIME_BITS'(r_press_timeout)) begin
                    n_pressed = 1'b0;
                end
            end
            default: begin
                n_phase = PH_DRIVE;
            end
        endcase
    end

    always_comb begin
        o_result.drive_high    = n_pin_driven;
        o_result.measure_done  = done;
        o_result.elapsed_ticks = done ? ELAPSED_W'(diff) : '0;
        o_result.button_code   = done ? button : BTN_NONE;
        o_result.pressed       = n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_DRIVE;
            r_charge_count <= '0;
            r_start_stamp  <= '0;
            r_pressed      <= 1'b0;
            r_pin_driven   <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_charge_count <= n_charge_count;
            r_start_stamp  <= n_start_stamp;
            r_pressed      <= n_pressed;
            r_pin_driven   <= n_pin_driven;
        end
    end

endmodule

`default_nettype wire

@@ src/rcbd_out_stage.sv @@
// Result register of the RC discharge button decoder.
// Holds one result word until the receiver takes it; depends on rcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcbd_out_stage (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  rcbd_pkg::t_result               i_result,
    output logic                            o_advance,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_drive_high,
    output logic                            o_measure_done,
    output logic [rcbd_pkg::ELAPSED_W-1:0]  o_elapsed_ticks,
    output logic [rcbd_pkg::BUTTON_W-1:0]   o_button_code,
    output logic                            o_pressed
);
    import rcbd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance       = !r_valid || i_out_ready;
    assign o_out_valid     = r_valid;
    assign o_drive_high    = r_result.drive_high;
    assign o_measure_done  = r_result.measure_done;
    assign o_elapsed_ticks = r_result.elapsed_ticks;
    assign o_button_code   = r_result.button_code;
    assign o_pressed       = r_result.pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

@@ src/rcbd_checker.sv @@
// Port-level checks for the RC discharge button decoder, bound to the top level.
// Depends on rcbd_pkg and rc_discharge_button_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module rcbd_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_out_valid,
    input wire                              i_out_ready,
    input wire                              o_drive_high,
    input wire                              o_measure_done,
    input wire [rcbd_pkg::ELAPSED_W-1:0]    o_elapsed_ticks,
    input wire [rcbd_pkg::BUTTON_W-1:0]     o_button_code,
    input wire                              o_pressed
);
    import rcbd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_elapsed_ticks)
            && $stable(o_button_code) && $stable(o_measure_done) && $stable(o_pressed))
        else $error("stalled result word changed");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_measure_done |-> o_elapsed_ticks == '0
            && o_button_code == BUTTON_W'(BTN_NONE))
        else $error("capture fields set without a capture");

    a_capture_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_measure_done |-> !o_drive_high)
        else $error("capture reported while the line is driven");

    a_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_button_code <= BUTTON_W'(BTN_REV))
        else $error("button code out of range");

endmodule

bind rc_discharge_button_decoder_top rcbd_checker u_rcbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_drive_high    (o_drive_high),
    .o_measure_done  (o_measure_done),
    .o_elapsed_ticks (o_elapsed_ticks),
    .o_button_code   (o_button_code),
    .o_pressed       (o_pressed)
);

`default_nettype wire

@@ tb/rcbd_result_checker.sv @@
// Scoreboard for the RC discharge button decoder: it watches the poll, result and register
// channels, runs its own copy of the sense phase machine and compares every result word.
// Depends on rcbd_pkg.
`timescale 1ns / 1ps

module rcbd_result_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  wire                              i_comparator_high,
    input  wire  [rcbd_pkg::TIME_BITS-1:0]   i_time_now,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  wire                              i_drive_high,
    input  wire                              i_measure_done,
    input  wire  [rcbd_pkg::ELAPSED_W-1:0]   i_elapsed_ticks,
    input  wire  [rcbd_pkg::BUTTON_W-1:0]    i_button_code,
    input  wire                              i_pressed,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire  [rcbd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [rcbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    import rcbd_pkg::*;

    logic [CHARGE_W-1:0]  charge_polls;
    logic [TIMEOUT_W-1:0] press_timeout;
    t_phase               sense_phase;
    logic [CHARGE_W-1:0]  charge_count;
    logic [TIME_BITS-1:0] start_stamp;
    logic                 pressed_flag;
    logic                 line_driven;
    t_result              awaited_results[$];

    // The button follows from how many ladder thresholds the discharge time exceeds.
    function automatic t_button ladder_button(input logic [TIME_BITS-1:0] t);
        int rungs;
        rungs = int'(t > TH_REV) + int'(t > TH_PLAY) + int'(t > TH_FWD)
              + int'(t > TH_MINUS) + int'(t > TH_STOP) + int'(t > TH_VOL_MINUS)
              + int'(t > TH_VOL_PLUS) + int'(t > TH_PLUS) + int'(t > TH_NONE);
        case (rungs)
            1:       return BTN_REV;
            2:       return BTN_PLAY;
            3:       return BTN_FWD;
            4:       return BTN_MINUS;
            5:       return BTN_STOP;
            6:       return BTN_VOL_MINUS;
            7:       return BTN_VOL_PLUS;
            8:       return BTN_PLUS;
            default: return BTN_NONE;
        endcase
    endfunction

    task automatic predict_poll(input logic comp, input logic [TIME_BITS-1:0] now,
                                output t_result res);
        logic [TIME_BITS-1:0] diff;
        res  = '0;
        diff = now - start_stamp;
        case (sense_phase)
            PH_DRIVE: begin
                line_driven = 1'b1;
                sense_phase = PH_CHARGE;
            end
            PH_CHARGE: begin
                if (charge_count >= charge_polls) begin
                    sense_phase  = PH_RELEASE;
                    charge_count = '0;
                end else begin
                    charge_count = charge_count + CHARGE_W'(1);
                end
            end
            PH_RELEASE: begin
                start_stamp = now;
                line_driven = 1'b0;
                sense_phase = PH_WAIT;
            end
            default: begin
                if (comp) begin
                    res.measure_done  = 1'b1;
                    res.elapsed_ticks = diff;
                    res.button_code   = ladder_button(diff);
                    pressed_flag      = 1'b1;
                    sense_phase       = PH_DRIVE;
                end
                if (diff > press_timeout) begin
                    pressed_flag = 1'b0;
                end
            end
        endcase
        res.drive_high = line_driven;
        res.pressed    = pressed_flag;
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result fresh;
        t_result want;
        if (!i_rst_n) begin
            charge_polls  = CHARGE_POLLS_RESET;
            press_timeout = PRESS_TIMEOUT_RESET;
            sense_phase   = PH_DRIVE;
            charge_count  = '0;
            start_stamp   = '0;
            pressed_flag  = 1'b0;
            line_driven   = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result word expected none, got done=%0b elapsed=%0d",
                             $time, i_measure_done, i_elapsed_ticks);
                    o_mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("drive_high", 16'(want.drive_high), 16'(i_drive_high));
                    compare_field("measure_done", 16'(want.measure_done),
                                  16'(i_measure_done));
                    compare_field("elapsed_ticks", 16'(want.elapsed_ticks),
                                  16'(i_elapsed_ticks));
                    compare_field("button_code", 16'(want.button_code), 16'(i_button_code));
                    compare_field("pressed", 16'(want.pressed), 16'(i_pressed));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CHARGE_POLLS) begin
                    charge_polls = i_cfg_data[CHARGE_W-1:0];
                end else if (i_cfg_index == CFG_PRESS_TIMEOUT) begin
                    press_timeout = i_cfg_data[TIMEOUT_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_poll(i_comparator_high, i_time_now, fresh);
                awaited_results.push_back(fresh);
            end
        end
        o_outstanding = awaited_results.size();
    end

endmodule

@@ tb/rc_discharge_button_decoder_top_tb.sv @@
// Testbench top for the RC discharge button decoder: drives charge and discharge
// measurement sequences under several register settings and idle patterns.
// Depends on rcbd_pkg, rc_discharge_button_decoder_top and rcbd_result_checker.
`timescale 1ns / 1ps

module rc_discharge_button_decoder_top_tb;
    import rcbd_pkg::*;

    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_in_valid        = 1'b0;
    logic                   i_comparator_high = 1'b0;
    logic [TIME_BITS-1:0]   i_time_now        = '0;
    logic                   i_out_ready       = 1'b0;
    logic                   i_cfg_valid       = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index       = CFG_CHARGE_POLLS;
    logic [CFG_DATA_W-1:0]  i_cfg_data        = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_drive_high;
    logic                   o_measure_done;
    logic [ELAPSED_W-1:0]   o_elapsed_ticks;
    logic [BUTTON_W-1:0]    o_button_code;
    logic                   o_pressed;
    logic                   o_cfg_ready;

    int mismatches;
    int outstanding;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int polls_sent    = 0;
    logic [TIME_BITS-1:0] tick = '0;
    logic [TIME_BITS-1:0] ladder_edges [9] = '{TH_REV, TH_PLAY, TH_FWD, TH_MINUS, TH_STOP,
                                               TH_VOL_MINUS, TH_VOL_PLUS, TH_PLUS, TH_NONE};

    rc_discharge_button_decoder_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_comparator_high (i_comparator_high),
        .i_time_now        (i_time_now),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_drive_high      (o_drive_high),
        .o_measure_done    (o_measure_done),
        .o_elapsed_ticks   (o_elapsed_ticks),
        .o_button_code     (o_button_code),
        .o_pressed         (o_pressed),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    rcbd_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_comparator_high (i_comparator_high),
        .i_time_now        (i_time_now),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_drive_high      (o_drive_high),
        .i_measure_done    (o_measure_done),
        .i_elapsed_ticks   (o_elapsed_ticks),
        .i_button_code     (o_button_code),
        .i_pressed         (o_pressed),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_poll(input logic comp, input logic [TIME_BITS-1:0] stamp);
        if ($urandom_range(0, 99) == 0) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (outstanding != 0);
        end
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_comparator_high <= comp;
        i_time_now        <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        polls_sent++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // One full sense cycle starting from the drive phase and ending on a comparator trip.
    task automatic run_measurement(input int charge, input logic [TIME_BITS-1:0] release_at,
                                   input logic [TIME_BITS-1:0] elapsed, input int waits,
                                   input logic scatter);
        logic [TIME_BITS-1:0] t;
        send_poll(1'($urandom), tick);
        repeat (charge + 1) begin
            tick = tick + TIME_BITS'($urandom_range(0, 3));
            send_poll(1'($urandom), tick);
        end
        send_poll(1'($urandom), release_at);
        for (int j = 1; j <= waits; j++) begin
            t = scatter ? TIME_BITS'($urandom)
                        : release_at + TIME_BITS'((longint'(elapsed) * j) / (waits + 1));
            send_poll(1'b0, t);
        end
        tick = release_at + elapsed;
        send_poll(1'b1, tick);
    endtask

    task automatic run_phase(input logic [CHARGE_W-1:0] charge,
                             input logic [TIMEOUT_W-1:0] timeout,
                             input int snd, input int rcv, input int n);
        logic [CFG_DATA_W-1:0] charge_word;
        logic [TIME_BITS-1:0]  elapsed;
        logic [TIME_BITS-1:0]  stamp;
        int                    waits;
        int                    stop_at;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
        charge_word                 = CFG_DATA_W'($urandom);
        charge_word[CHARGE_W-1:0]   = charge;
        write_reg(CFG_CHARGE_POLLS, charge_word);
        write_reg(CFG_PRESS_TIMEOUT, timeout);
        i_cfg_valid   <= 1'b0;
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        stop_at       = polls_sent + n;
        while (polls_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: elapsed = ladder_edges[$urandom_range(0, 8)]
                                         + TIME_BITS'($urandom_range(0, 2)) - TIME_BITS'(1);
                5, 6:          elapsed = TIME_BITS'($urandom_range(0, 300));
                7, 8:          elapsed = timeout + TIME_BITS'($urandom_range(0, 2))
                                         - TIME_BITS'(1);
                default:       elapsed = TIME_BITS'($urandom);
            endcase
            waits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
            stamp = ($urandom_range(0, 4) == 0) ? TIME_BITS'($urandom)
                                                : tick + TIME_BITS'($urandom_range(0, 5));
            run_measurement(int'(charge), stamp, elapsed, waits, $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_CHARGE_POLLS, CFG_DATA_W'(0));
        i_cfg_valid <= 1'b0;
        run_measurement(0, '0, '0, 0, 1'b0);
        run_measurement(0, TIME_BITS'(100), TH_REV + TIME_BITS'(1), 0, 1'b0);
        run_measurement(0, TIME_BITS'(5000), TH_NONE + TIME_BITS'(1), 1, 1'b0);
        run_measurement(0, '1, '1, 0, 1'b0);
        run_measurement(0, TIME_BITS'(300), TIME_BITS'(100), 2, 1'b1);

        run_phase(8'd0, 16'd1000, 0, 0, 190);
        run_phase(8'd1, 16'd0, 56, 0, 190);
        run_phase(8'd3, 16'hFFFF, 0, 56, 190);
        run_phase(8'd255, 16'd200, 21, 21, 190);
        run_phase(8'd2, 16'd150, 0, 0, 190);
        run_phase(CHARGE_W'($urandom_range(0, 7)), TIMEOUT_W'($urandom), 56, 0, 190);
        run_phase(CHARGE_POLLS_RESET, PRESS_TIMEOUT_RESET, 0, 56, 190);
        run_phase(8'd5, 16'hFFFE, 21, 21, 190);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/rcbd_pkg.sv
src/rcbd_in_stage.sv
src/rcbd_core.sv
src/rcbd_out_stage.sv
src/rc_discharge_button_decoder_top.sv
src/rcbd_checker.sv
tb/rcbd_result_checker.sv
tb/rc_discharge_button_decoder_top_tb.sv
